// ----- hw/rtl/dwr_pkg.sv -----
// ----------------------------------------------------------------------------
// dwr_pkg
// Shared field widths, request/status codes and controller state encoding
// for the draw-without-replacement block.
// ----------------------------------------------------------------------------
package dwr_pkg;

    localparam int RND_W  = 31;
    localparam int NUM_W  = 8;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 8;

    localparam logic [CFG_W-1:0] POOL_SIZE_RST = 8'd75;

    localparam logic REQ_REFILL = 1'b0;
    localparam logic REQ_DRAW   = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_DRAWN    = 2'd0,
        STAT_REFILLED = 2'd1,
        STAT_EMPTY    = 2'd2
    } status_t;

    typedef enum logic [5:0] {
        ST_FILL  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_COUNT = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_FIND  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

// ----- hw/rtl/dwr_ram.sv -----
// ----------------------------------------------------------------------------
// dwr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dwr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/draw_without_replacement_top.sv -----
// ----------------------------------------------------------------------------
// draw_without_replacement_top
// Draws numbered items 1..pool_size without replacement; presence marks in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per transfer. s_tuser = 0 refills the pool,
//   1 draws one item using s_tdata as the random value.
//   m_ channel: exactly one result per request, m_tdata = drawn number
//   (0 when nothing drawn), m_tuser = status (0 drawn, 1 refilled, 2 empty).
//   cfg_ channel: writes pool_size (reset 75); values above POOL_MAX act as
//   POOL_MAX. cfg_ready is high only while idle with no result waiting, and
//   a pending write holds s_tready low.
// Operation:
//   Refill: one presence mark written per cycle over all POOL_MAX marks.
//   Draw: a first scan counts the remaining items, the remainder is then
//   formed one quotient bit per cycle, a second scan runs up to the chosen
//   item, and the result is handed off; the presence RAM has one port each
//   way, so each scan visits one mark per cycle.
// Reset: a fill pass over all POOL_MAX marks sets every item present;
//   s_tready stays low until it completes.
// Stall: a finished result waits in the output register; the next request is
//   accepted meanwhile, and its result waits until the register drains.
// ----------------------------------------------------------------------------
module draw_without_replacement_top #(
    parameter int POOL_MAX = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,     // [7:0] pool_size
    // requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // [30:0] random_value, [31] zero
    input  logic        s_tuser,      // [0] req_type
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // [7:0] drawn_number
    output logic [1:0]  m_tuser       // [1:0] status
);

    localparam int AW = $clog2(POOL_MAX);
    localparam int CW = $clog2(POOL_MAX + 1);
    localparam int EW = (CW > dwr_pkg::CFG_W) ? CW : dwr_pkg::CFG_W;
    localparam int NW = (AW + 1 > dwr_pkg::NUM_W) ? AW + 1 : dwr_pkg::NUM_W;
    localparam int RW = dwr_pkg::RND_W;

    dwr_pkg::state_t  state_reg, state_next;
    logic [dwr_pkg::CFG_W-1:0] pool_size_reg;
    logic [CW-1:0]    addr_reg, addr_next;
    logic [AW-1:0]    rd_idx_reg, rd_idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [RW-1:0]    rnd_reg, rnd_next;
    logic [4:0]       step_reg, step_next;
    logic             rep_reg, rep_next;
    logic [dwr_pkg::NUM_W-1:0] res_num_reg, res_num_next;
    dwr_pkg::status_t res_stat_reg, res_stat_next;
    logic             m_valid_reg, m_valid_next;
    logic [dwr_pkg::NUM_W-1:0] m_num_reg, m_num_next;
    dwr_pkg::status_t m_stat_reg, m_stat_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic             ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic             ram_rdata;

    logic [EW-1:0]    size_ext;
    logic [CW-1:0]    size;
    logic             issue;
    logic [CW:0]      div_trial;
    logic [NW-1:0]    num_ext;
    logic             out_free;

    // effective pool size, clamped to the RAM depth
    assign size_ext = EW'(pool_size_reg);
    assign size     = (size_ext > EW'(POOL_MAX)) ? CW'(POOL_MAX) : CW'(size_ext);
    assign issue    = (addr_reg < size);
    assign div_trial = {rem_reg, rnd_reg[RW-1]};
    assign num_ext  = NW'(rd_idx_reg) + NW'(1);
    assign out_free = !m_valid_reg || m_tready;

    dwr_ram #(
        .WIDTH (1),
        .DEPTH (POOL_MAX)
    ) u_marks (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        rd_idx_next   = rd_idx_reg;
        rd_vld_next   = 1'b0;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        rnd_next      = rnd_reg;
        step_next     = step_reg;
        rep_next      = rep_reg;
        res_num_next  = res_num_reg;
        res_stat_next = res_stat_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_num_next    = m_num_reg;
        m_stat_next   = m_stat_reg;
        ram_we        = 1'b0;
        ram_waddr     = addr_reg[AW-1:0];
        ram_wdata     = 1'b1;
        ram_raddr     = addr_reg[AW-1:0];
        s_tready      = 1'b0;

        case (state_reg)
            dwr_pkg::ST_FILL: begin
                ram_we = 1'b1;
                if (addr_reg == CW'(POOL_MAX - 1)) begin
                    res_num_next  = '0;
                    res_stat_next = dwr_pkg::STAT_REFILLED;
                    state_next    = rep_reg ? dwr_pkg::ST_DONE : dwr_pkg::ST_IDLE;
                end else begin
                    addr_next = addr_reg + CW'(1);
                end
            end
            dwr_pkg::ST_IDLE: begin
                // a pending register write goes first
                s_tready = !cfg_valid;
                if (s_tvalid && !cfg_valid) begin
                    addr_next = '0;
                    if (s_tuser == dwr_pkg::REQ_REFILL) begin
                        rep_next   = 1'b1;
                        state_next = dwr_pkg::ST_FILL;
                    end else begin
                        rnd_next   = s_tdata[RW-1:0];
                        cnt_next   = '0;
                        state_next = dwr_pkg::ST_COUNT;
                    end
                end
            end
            dwr_pkg::ST_COUNT: begin
                if (issue) begin
                    addr_next   = addr_reg + CW'(1);
                    rd_idx_next = addr_reg[AW-1:0];
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg) begin
                    cnt_next = cnt_reg + CW'(ram_rdata);
                end
                if (!issue && !rd_vld_reg) begin
                    if (cnt_reg == '0) begin
                        res_num_next  = '0;
                        res_stat_next = dwr_pkg::STAT_EMPTY;
                        state_next    = dwr_pkg::ST_DONE;
                    end else begin
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = dwr_pkg::ST_DIV;
                    end
                end
            end
            dwr_pkg::ST_DIV: begin
                // restoring remainder step, one random bit per cycle
                if (div_trial >= {1'b0, cnt_reg}) begin
                    rem_next = CW'(div_trial - {1'b0, cnt_reg});
                end else begin
                    rem_next = CW'(div_trial);
                end
                rnd_next  = {rnd_reg[RW-2:0], 1'b0};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(RW - 1)) begin
                    addr_next  = '0;
                    state_next = dwr_pkg::ST_FIND;
                end
            end
            dwr_pkg::ST_FIND: begin
                // rem_reg now holds the rank among present items
                if (rd_vld_reg && ram_rdata && rem_reg == '0) begin
                    ram_we        = 1'b1;
                    ram_waddr     = rd_idx_reg;
                    ram_wdata     = 1'b0;
                    res_num_next  = num_ext[dwr_pkg::NUM_W-1:0];
                    res_stat_next = dwr_pkg::STAT_DRAWN;
                    state_next    = dwr_pkg::ST_DONE;
                end else begin
                    if (rd_vld_reg && ram_rdata) begin
                        rem_next = rem_reg - CW'(1);
                    end
                    if (issue) begin
                        addr_next   = addr_reg + CW'(1);
                        rd_idx_next = addr_reg[AW-1:0];
                        rd_vld_next = 1'b1;
                    end else if (!rd_vld_reg) begin
                        res_num_next  = '0;
                        res_stat_next = dwr_pkg::STAT_EMPTY;
                        state_next    = dwr_pkg::ST_DONE;
                    end
                end
            end
            dwr_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_num_next   = res_num_reg;
                    m_stat_next  = res_stat_reg;
                    state_next   = dwr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dwr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dwr_pkg::ST_FILL;
            addr_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            rep_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
            pool_size_reg <= dwr_pkg::POOL_SIZE_RST;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            rd_vld_reg  <= rd_vld_next;
            rep_reg     <= rep_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                pool_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        rnd_reg      <= rnd_next;
        step_reg     <= step_next;
        res_num_reg  <= res_num_next;
        res_stat_reg <= res_stat_next;
        m_num_reg    <= m_num_next;
        m_stat_reg   <= m_stat_next;
    end

    assign cfg_ready = (state_reg == dwr_pkg::ST_IDLE) && !m_valid_reg;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_num_reg;
    assign m_tuser   = m_stat_reg;

    // rank must stay below the remaining count throughout the search
    a_rank_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dwr_pkg::ST_FIND |-> rem_reg < cnt_reg)
        else $error("rank not below remaining count");

    // remaining count never exceeds the effective pool size
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dwr_pkg::ST_DIV |-> cnt_reg <= size)
        else $error("remaining count above pool size");

    // marks change only during the refill pass or when an item is taken
    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == dwr_pkg::ST_FILL || state_reg == dwr_pkg::ST_FIND))
        else $error("mark RAM written outside fill or find");

    // a drawn result carries a nonzero number
    a_drawn_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == dwr_pkg::STAT_DRAWN && POOL_MAX < 256)
            |-> m_tdata != '0)
        else $error("drawn result with number zero");

endmodule

// ----- tb/tb_draw_without_replacement_top.sv -----
// ----------------------------------------------------------------------------
// tb_draw_without_replacement_top
// Self-checking bench for the draw-without-replacement block. A scoreboard
// keeps its own presence marks and pool size, predicts each result when the
// request transfer is taken and compares results in order. A directed pass
// covers the value extremes, an empty pool, pool sizes zero, one, the maximum
// and above it, and a size change without a refill. Random phases then follow
// over several pool sizes, with random gaps on both streams in most phases.
// ----------------------------------------------------------------------------
module tb_draw_without_replacement_top;

    localparam int POOL_MAX    = 128;
    localparam int STALL_LIMIT = 5000;  // cycles with no transfer at all
    localparam int SETTLE      = 300;

    typedef struct packed {
        logic [dwr_pkg::NUM_W-1:0] number;
        dwr_pkg::status_t          status;
    } draw_result_t;

    class pool_scoreboard;
        bit                        present [POOL_MAX];
        int unsigned               taken_count;
        logic [dwr_pkg::CFG_W-1:0] pool_size;
        draw_result_t              owed_results[$];
        int                        errors  = 0;
        int                        draws   = 0;
        int                        refills = 0;
        int                        empties = 0;

        function new();
            refill();
            pool_size = dwr_pkg::POOL_SIZE_RST;
        endfunction

        function void refill();
            foreach (present[i]) present[i] = 1'b1;
            taken_count = 0;
        endfunction

        function void set_pool_size(logic [dwr_pkg::CFG_W-1:0] v);
            pool_size = v;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function draw_result_t predict_draw(logic req, logic [dwr_pkg::RND_W-1:0] rnd);
            draw_result_t r;
            int unsigned  size;
            int unsigned  remaining;
            int unsigned  rank;
            r.number = '0;
            r.status = dwr_pkg::STAT_EMPTY;
            if (req == dwr_pkg::REQ_REFILL) begin
                refill();
                r.status = dwr_pkg::STAT_REFILLED;
                refills++;
                return r;
            end
            draws++;
            size = (pool_size > POOL_MAX) ? POOL_MAX : pool_size;
            remaining = 0;
            for (int i = 0; i < size; i++) remaining += present[i];
            if (remaining == 0) begin
                empties++;
                return r;
            end
            rank = rnd % remaining;
            // walk to the present item of that rank, counting from item 1
            for (int i = 0; i < size; i++) begin
                if (present[i]) begin
                    if (rank == 0) begin
                        present[i] = 1'b0;
                        if (taken_count < 255) taken_count++;
                        r.number = dwr_pkg::NUM_W'(i + 1);
                        r.status = dwr_pkg::STAT_DRAWN;
                        return r;
                    end
                    rank--;
                end
            end
            return r;
        endfunction

        function void note_request(logic req, logic [dwr_pkg::RND_W-1:0] rnd);
            owed_results.push_back(predict_draw(req, rnd));
        endfunction

        task report(string what, int got, int want);
            errors++;
            if (errors <= 40) $display("ERROR %s: got %0d, expected %0d", what, got, want);
        endtask

        task check_result(logic [dwr_pkg::NUM_W-1:0] num, logic [dwr_pkg::STAT_W-1:0] stat);
            draw_result_t want;
            if (owed_results.size() == 0) begin
                report("result with nothing outstanding, status", stat, 0);
                return;
            end
            want = owed_results.pop_front();
            if (num !== want.number) report("drawn number", num, want.number);
            if (stat !== want.status) report("status", stat, want.status);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;

    pool_scoreboard sb;

    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int rx_gap  = 0;
    int phases  = 0;

    draw_without_replacement_top #(.POOL_MAX(POOL_MAX)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // monitors
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tuser, s_tdata[dwr_pkg::RND_W-1:0]);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        if (aresetn && cfg_valid && cfg_ready) sb.set_pool_size(cfg_data);
    end

    // result side back-pressure, in bursts
    always @(negedge aclk) begin
        if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap = rx_gap - 1;
        end else begin
            m_tready <= 1'b1;
            if (rx_gaps && $urandom_range(0, 9) == 0) rx_gap = $urandom_range(1, 11);
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("tb_draw_without_replacement_top NOT OK");
        $finish;
    end

    function automatic logic [dwr_pkg::RND_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return dwr_pkg::RND_W'($urandom_range(0, 300));
            default: return dwr_pkg::RND_W'($urandom);
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(logic req, logic [dwr_pkg::RND_W-1:0] rnd);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {1'b0, rnd};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_pool_size(logic [dwr_pkg::CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [dwr_pkg::CFG_W-1:0] size, int n_items);
        drain();
        write_pool_size(size);
        phases++;
        if ($urandom_range(0, 1)) send_request(dwr_pkg::REQ_REFILL, rand_value());
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 6)
                send_request(dwr_pkg::REQ_REFILL, rand_value());
            else
                send_request(dwr_pkg::REQ_DRAW, rand_value());
        end
    endtask

    initial begin : stimulus
        logic [dwr_pkg::CFG_W-1:0] sizes [10];
        sb        = new();
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = dwr_pkg::REQ_REFILL;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // reset pool size, extremes of the random value
        send_request(dwr_pkg::REQ_DRAW, '0);
        send_request(dwr_pkg::REQ_DRAW, '1);
        send_request(dwr_pkg::REQ_DRAW, 31'h2AAA_AAAA);
        send_request(dwr_pkg::REQ_DRAW, 31'h5555_5555);
        send_request(dwr_pkg::REQ_REFILL, '1);
        // single item pool runs dry
        drain();
        write_pool_size(8'd1);
        send_request(dwr_pkg::REQ_DRAW, 31'd5);
        send_request(dwr_pkg::REQ_DRAW, '0);
        send_request(dwr_pkg::REQ_REFILL, '0);
        send_request(dwr_pkg::REQ_DRAW, '1);
        // empty by size
        drain();
        write_pool_size(8'd0);
        send_request(dwr_pkg::REQ_DRAW, '1);
        send_request(dwr_pkg::REQ_REFILL, 31'd3);
        send_request(dwr_pkg::REQ_DRAW, '0);
        // above the maximum acts as the maximum
        drain();
        write_pool_size(8'd255);
        send_request(dwr_pkg::REQ_DRAW, 31'd127);
        send_request(dwr_pkg::REQ_DRAW, 31'd128);
        drain();
        write_pool_size(8'd128);
        send_request(dwr_pkg::REQ_DRAW, '1);
        // shrink without refill: only marks inside the new size count
        drain();
        write_pool_size(8'd3);
        send_request(dwr_pkg::REQ_DRAW, '0);
        send_request(dwr_pkg::REQ_DRAW, '0);
        send_request(dwr_pkg::REQ_DRAW, '0);
        send_request(dwr_pkg::REQ_DRAW, '1);

        sizes = '{8'd128, 8'd255, 8'd2, 8'd64, 8'd1, 8'd0, 8'd200, 8'd9, 8'd0, 8'd75};
        sizes[8] = dwr_pkg::CFG_W'($urandom_range(1, 127));
        for (int p = 0; p < 10; p++) begin
            // no gaps in one phase in the middle, nor in the last one
            tx_gaps = (p != 3) && (p != 9);
            rx_gaps = tx_gaps;
            run_phase(sizes[p], 50);
        end

        drain();
        repeat (SETTLE) @(negedge aclk);
        $display("covered %0d draws (%0d from an empty pool) and %0d refills",
                 sb.draws, sb.empties, sb.refills);
        $display("over %0d random pool size phases plus directed cases; %0d mismatches",
                 phases, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_draw_without_replacement_top OK");
        else
            $display("tb_draw_without_replacement_top NOT OK");
        $finish;
    end

endmodule
